/* sv/rfd_pkg.sv */
// ----------------------------------------------------------------------------
// rfd_pkg
// shared types of the rpc frame deframer: register set and result item
// ----------------------------------------------------------------------------
`default_nettype none

package rfd_pkg;

  typedef struct packed {
    logic [7:0]  start_marker;
    logic [7:0]  end_marker;
    logic [15:0] max_frame_bytes;
    logic [7:0]  max_id_bytes;
    logic [9:0]  max_method_bytes;
    logic [9:0]  max_info_bytes;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [31:0] word;
    logic [1:0]  reason;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

/* sv/rfd_parser.sv */
// ----------------------------------------------------------------------------
// rfd_parser
// per-byte phase machine: hunts the start marker, gathers length words,
// streams field bytes and the error code, checks lengths and the end marker
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_parser import rfd_pkg::*; #(
  parameter int unsigned LenBits = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       byte_valid_i,
  input  wire logic [7:0] byte_i,
  output logic            res_valid_o,
  output res_t            res_o
);

  localparam int unsigned CntW = (LenBits < 16) ? LenBits : 16;

  localparam logic [2:0] KindId      = 3'd0;
  localparam logic [2:0] KindMethod  = 3'd1;
  localparam logic [2:0] KindInfo    = 3'd2;
  localparam logic [2:0] KindPayload = 3'd3;
  localparam logic [2:0] KindErrCode = 3'd4;
  localparam logic [2:0] KindAccept  = 3'd5;
  localparam logic [2:0] KindReject  = 3'd6;

  localparam logic [1:0] ReasonLength = 2'd1;
  localparam logic [1:0] ReasonField  = 2'd2;
  localparam logic [1:0] ReasonEnd    = 2'd3;

  localparam logic [31:0] FrameOverhead   = 32'd26;
  localparam logic [31:0] HeaderBytes     = 32'd5;
  localparam logic [31:0] TailAfterId     = 32'd17;
  localparam logic [31:0] TailAfterMethod = 32'd13;
  localparam logic [31:0] TailAfterInfo   = 32'd5;

  typedef enum logic [3:0] {
    PhHunt,
    PhTotal,
    PhIdLen,
    PhId,
    PhMethLen,
    PhMethod,
    PhErrCode,
    PhInfoLen,
    PhInfo,
    PhPayload,
    PhCsum,
    PhEnd,
    PhSkip
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [31:0]       shift_q, shift_d;
  logic [1:0]        wcnt_q, wcnt_d;
  logic [CntW-1:0]   frame_left_q, frame_left_d;
  logic [CntW-1:0]   field_left_q, field_left_d;

  logic [31:0]       word_new;
  logic              word_done;
  logic [CntW-1:0]   frame_dec;
  logic [CntW-1:0]   field_dec;
  logic              total_bad;
  logic [CntW-1:0]   payload_len;
  logic              payload_some;

  function automatic logic len_ok(logic [31:0] len, logic [31:0] limit,
                                  logic [CntW-1:0] left, logic [31:0] tail);
    logic [31:0] left_w;
    left_w = 32'(left);
    return (len <= limit) && (left_w >= tail) && (len <= left_w - tail);
  endfunction

  assign word_new  = {shift_q[23:0], byte_i};
  assign word_done = (wcnt_q == 2'd3);
  assign frame_dec = (frame_left_q != '0) ? frame_left_q - CntW'(1) : frame_left_q;
  assign field_dec = (field_left_q != '0) ? field_left_q - CntW'(1) : field_left_q;
  assign total_bad = ((word_new >> LenBits) != 32'd0)
                   || (word_new > 32'(cfg_i.max_frame_bytes))
                   || (word_new < FrameOverhead);
  assign payload_some = (32'(frame_dec) > TailAfterInfo);
  assign payload_len  = frame_dec - CntW'(TailAfterInfo);

  always_comb begin
    phase_d      = phase_q;
    shift_d      = shift_q;
    wcnt_d       = wcnt_q;
    frame_left_d = frame_left_q;
    field_left_d = field_left_q;
    res_valid_o  = 1'b0;
    res_o        = '0;

    if (byte_valid_i) begin
      if (phase_q != PhHunt && phase_q != PhTotal) begin
        frame_left_d = frame_dec;
      end
      if (phase_q == PhTotal || phase_q == PhIdLen || phase_q == PhMethLen ||
          phase_q == PhErrCode || phase_q == PhInfoLen || phase_q == PhCsum) begin
        shift_d = word_new;
        wcnt_d  = wcnt_q + 2'd1;
      end

      case (phase_q)
        PhHunt: begin
          if (byte_i == cfg_i.start_marker) begin
            phase_d = PhTotal;
            shift_d = '0;
            wcnt_d  = '0;
          end
        end
        PhTotal: begin
          if (word_done) begin
            if (total_bad) begin
              phase_d       = PhHunt;
              res_valid_o   = 1'b1;
              res_o.kind    = KindReject;
              res_o.reason  = ReasonLength;
              res_o.last    = 1'b1;
            end else begin
              frame_left_d = CntW'(word_new - HeaderBytes);
              phase_d      = PhIdLen;
            end
          end
        end
        PhIdLen: begin
          if (word_done) begin
            if (!len_ok(word_new, 32'(cfg_i.max_id_bytes), frame_dec, TailAfterId)) begin
              phase_d = PhSkip;
            end else if (word_new != 32'd0) begin
              field_left_d = CntW'(word_new);
              phase_d      = PhId;
            end else begin
              phase_d = PhMethLen;
            end
          end
        end
        PhMethLen: begin
          if (word_done) begin
            if (!len_ok(word_new, 32'(cfg_i.max_method_bytes), frame_dec,
                        TailAfterMethod)) begin
              phase_d = PhSkip;
            end else if (word_new != 32'd0) begin
              field_left_d = CntW'(word_new);
              phase_d      = PhMethod;
            end else begin
              phase_d = PhErrCode;
            end
          end
        end
        PhErrCode: begin
          if (word_done) begin
            phase_d     = PhInfoLen;
            res_valid_o = 1'b1;
            res_o.kind  = KindErrCode;
            res_o.word  = word_new;
          end
        end
        PhInfoLen: begin
          if (word_done) begin
            if (!len_ok(word_new, 32'(cfg_i.max_info_bytes), frame_dec, TailAfterInfo)) begin
              phase_d = PhSkip;
            end else if (word_new != 32'd0) begin
              field_left_d = CntW'(word_new);
              phase_d      = PhInfo;
            end else if (payload_some) begin
              field_left_d = payload_len;
              phase_d      = PhPayload;
            end else begin
              phase_d = PhCsum;
            end
          end
        end
        PhId, PhMethod, PhInfo, PhPayload: begin
          field_left_d = field_dec;
          res_valid_o  = 1'b1;
          res_o.data   = byte_i;
          case (phase_q)
            PhId:     res_o.kind = KindId;
            PhMethod: res_o.kind = KindMethod;
            PhInfo:   res_o.kind = KindInfo;
            default:  res_o.kind = KindPayload;
          endcase
          if (field_dec == '0) begin
            case (phase_q)
              PhId:     phase_d = PhMethLen;
              PhMethod: phase_d = PhErrCode;
              PhInfo: begin
                if (payload_some) begin
                  field_left_d = payload_len;
                  phase_d      = PhPayload;
                end else begin
                  phase_d = PhCsum;
                end
              end
              default:  phase_d = PhCsum;
            endcase
          end
        end
        PhCsum: begin
          if (word_done) begin
            phase_d = PhEnd;
          end
        end
        PhEnd: begin
          phase_d     = PhHunt;
          res_valid_o = 1'b1;
          res_o.last  = 1'b1;
          if (byte_i == cfg_i.end_marker) begin
            res_o.kind = KindAccept;
          end else begin
            res_o.kind   = KindReject;
            res_o.reason = ReasonEnd;
          end
        end
        PhSkip: begin
          if (frame_dec == '0) begin
            phase_d      = PhHunt;
            res_valid_o  = 1'b1;
            res_o.kind   = KindReject;
            res_o.reason = ReasonField;
            res_o.last   = 1'b1;
          end
        end
        default: begin
          phase_d = PhHunt;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhHunt;
      shift_q      <= '0;
      wcnt_q       <= '0;
      frame_left_q <= '0;
      field_left_q <= '0;
    end else begin
      phase_q      <= phase_d;
      shift_q      <= shift_d;
      wcnt_q       <= wcnt_d;
      frame_left_q <= frame_left_d;
      field_left_q <= field_left_d;
    end
  end

endmodule

`default_nettype wire

/* sv/rpc_frame_deframer.sv */
// results: a result is registered in the output buffer before it is on the output ports
// throughput: one byte per cycle while the output buffer is not full, set by the single-pass phase machine
// a two-entry output buffer keeps bytes flowing while a result waits
// reset: hunting for the start marker, registers at their defaults,
// output buffer empty
// ----------------------------------------------------------------------------
// rpc_frame_deframer
// length-prefixed rpc frame parser with apb register port and output buffer
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_frame_deframer import rfd_pkg::*; #(
  parameter int unsigned LenBits = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         rx_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [2:0]              field_kind_o,
  output logic [7:0]              data_byte_o,
  output logic signed [31:0]      error_code_word_o,
  output logic [1:0]              reject_reason_o,
  output logic                    frame_last_o
);

  localparam logic [2:0] RegStartMarker = 3'd0;
  localparam logic [2:0] RegEndMarker   = 3'd1;
  localparam logic [2:0] RegMaxFrame    = 3'd2;
  localparam logic [2:0] RegMaxId       = 3'd3;
  localparam logic [2:0] RegMaxMethod   = 3'd4;
  localparam logic [2:0] RegMaxInfo     = 3'd5;

  cfg_t        cfg_q;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  logic        in_xfer;
  logic        res_valid;
  res_t        res;
  logic        push;
  logic        pop;
  logic [1:0]  ocnt_q, ocnt_d;
  res_t        head_q, head_d;
  res_t        slot_q, slot_d;

  // register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker     <= 8'd2;
      cfg_q.end_marker       <= 8'd3;
      cfg_q.max_frame_bytes  <= 16'd4096;
      cfg_q.max_id_bytes     <= 8'd32;
      cfg_q.max_method_bytes <= 10'd256;
      cfg_q.max_info_bytes   <= 10'd256;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegStartMarker: cfg_q.start_marker     <= pwdata[7:0];
        RegEndMarker:   cfg_q.end_marker       <= pwdata[7:0];
        RegMaxFrame:    cfg_q.max_frame_bytes  <= pwdata[15:0];
        RegMaxId:       cfg_q.max_id_bytes     <= pwdata[7:0];
        RegMaxMethod:   cfg_q.max_method_bytes <= pwdata[9:0];
        RegMaxInfo:     cfg_q.max_info_bytes   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegStartMarker: prdata = 32'(cfg_q.start_marker);
      RegEndMarker:   prdata = 32'(cfg_q.end_marker);
      RegMaxFrame:    prdata = 32'(cfg_q.max_frame_bytes);
      RegMaxId:       prdata = 32'(cfg_q.max_id_bytes);
      RegMaxMethod:   prdata = 32'(cfg_q.max_method_bytes);
      RegMaxInfo:     prdata = 32'(cfg_q.max_info_bytes);
      default:        prdata = 32'd0;
    endcase
  end

  // parser
  assign in_ready_o = (ocnt_q != 2'd2);
  assign in_xfer    = in_valid_i & in_ready_o;

  rfd_parser #(
    .LenBits(LenBits)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .byte_valid_i (in_xfer),
    .byte_i       (rx_byte_i),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // two-entry output buffer
  assign push = in_xfer & res_valid;
  assign pop  = (ocnt_q != 2'd0) & out_ready_i;

  always_comb begin
    ocnt_d = ocnt_q;
    if (push && !pop) begin
      ocnt_d = ocnt_q + 2'd1;
    end else if (pop && !push) begin
      ocnt_d = ocnt_q - 2'd1;
    end

    head_d = head_q;
    if (ocnt_q == 2'd0 || pop) begin
      head_d = (ocnt_q == 2'd2) ? slot_q : res;
    end

    slot_d = slot_q;
    if (push && !pop && ocnt_q == 2'd1) begin
      slot_d = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= '0;
    end else begin
      ocnt_q <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    slot_q <= slot_d;
  end

  assign out_valid_o       = (ocnt_q != 2'd0);
  assign field_kind_o      = head_q.kind;
  assign data_byte_o       = head_q.data;
  assign error_code_word_o = $signed(head_q.word);
  assign reject_reason_o   = head_q.reason;
  assign frame_last_o      = head_q.last;

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// feeds byte streams of clean and damaged rpc frames into the deframer with
// random gaps on the input and random stalls on the output, and checks each
// result transfer against a built-in copy of the parser or a pinned result, under the reset
// register values, both extremes and a random setting
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import rfd_pkg::*;

  typedef enum logic [3:0] {
    S_HUNT, S_TOTAL, S_ID_LEN, S_ID, S_METHOD_LEN, S_METHOD, S_ERR_CODE,
    S_INFO_LEN, S_INFO, S_PAYLOAD, S_CHECKSUM, S_END, S_DRAIN
  } parse_e;

  typedef enum logic [2:0] {
    K_ID, K_METHOD, K_INFO, K_PAYLOAD, K_ERR_CODE, K_ACCEPT, K_REJECT
  } kind_e;

  typedef enum logic [1:0] {R_NONE, R_BAD_TOTAL, R_FIELD, R_END} reason_e;

  typedef enum logic [1:0] {BY_MODEL, PIN_QUIET, PIN_RESULT} check_e;

  typedef struct packed {
    logic [7:0] b;
    check_e     chk;
    res_t       res;
  } stim_t;

  localparam logic [4:0] A_START      = 5'd0;
  localparam logic [4:0] A_END        = 5'd4;
  localparam logic [4:0] A_MAX_FRAME  = 5'd8;
  localparam logic [4:0] A_MAX_ID     = 5'd12;
  localparam logic [4:0] A_MAX_METHOD = 5'd16;
  localparam logic [4:0] A_MAX_INFO   = 5'd20;

  localparam int unsigned LEN_BITS    = 16;
  localparam int unsigned FRAME_MIN   = 26;
  localparam int unsigned TAIL_ID     = 17;
  localparam int unsigned TAIL_METHOD = 13;
  localparam int unsigned TAIL_INFO   = 5;

  localparam cfg_t CFG_RESET = '{8'd2, 8'd3, 16'd4096, 8'd32, 10'd256, 10'd256};
  localparam cfg_t CFG_LOW   = '{8'h00, 8'hFF, 16'd26, 8'd0, 10'd0, 10'd0};
  localparam cfg_t CFG_HIGH  = '{8'hFF, 8'h00, 16'hFFFF, 8'hFF, 10'h3FF, 10'h3FF};

  localparam res_t NO_RES = '0;
  localparam res_t REJ_TOTAL = '{kind: K_REJECT, data: 8'h00, word: 32'h0,
                                 reason: R_BAD_TOTAL, last: 1'b1};

  // hunting noise and bad total lengths under the reset registers
  localparam stim_t DIRECTED [22] = '{
    '{8'hFF, PIN_QUIET, NO_RES}, '{8'h00, PIN_QUIET, NO_RES},
    '{8'h02, PIN_QUIET, NO_RES}, '{8'h00, PIN_QUIET, NO_RES},
    '{8'h00, PIN_QUIET, NO_RES}, '{8'h00, PIN_QUIET, NO_RES},
    '{8'h19, PIN_RESULT, REJ_TOTAL},
    '{8'h02, PIN_QUIET, NO_RES}, '{8'h00, PIN_QUIET, NO_RES},
    '{8'h00, PIN_QUIET, NO_RES}, '{8'h10, PIN_QUIET, NO_RES},
    '{8'h01, PIN_RESULT, REJ_TOTAL},
    '{8'h02, PIN_QUIET, NO_RES}, '{8'h00, PIN_QUIET, NO_RES},
    '{8'h01, PIN_QUIET, NO_RES}, '{8'h00, PIN_QUIET, NO_RES},
    '{8'h00, PIN_RESULT, REJ_TOTAL},
    '{8'h02, PIN_QUIET, NO_RES}, '{8'hFF, PIN_QUIET, NO_RES},
    '{8'hFF, PIN_QUIET, NO_RES}, '{8'hFF, PIN_QUIET, NO_RES},
    '{8'hFF, PIN_RESULT, REJ_TOTAL}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [4:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  rx_byte_i   = '0;
  logic        out_ready_i = 1'b0;

  logic [31:0]        prdata;
  logic               pready;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [2:0]         field_kind_o;
  logic [7:0]         data_byte_o;
  logic signed [31:0] error_code_word_o;
  logic [1:0]         reject_reason_o;
  logic               frame_last_o;

  rpc_frame_deframer i_dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_valid_i,
    .in_ready_o,
    .rx_byte_i,
    .out_valid_o,
    .out_ready_i,
    .field_kind_o,
    .data_byte_o,
    .error_code_word_o,
    .reject_reason_o,
    .frame_last_o
  );

  // parser copy
  cfg_t        cfg         = CFG_RESET;
  parse_e      ph          = S_HUNT;
  logic [31:0] shift_word  = '0;
  logic [1:0]  word_cnt    = '0;
  logic [15:0] frame_left  = '0;
  logic [15:0] field_left  = '0;
  reason_e     fail_reason = R_NONE;

  res_t        pending_results [$];
  logic [7:0]  frame_buf [$];
  stim_t       cur_item    = '0;
  logic        calm        = 1'b0;
  int unsigned errors      = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  task automatic note(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  function automatic int unsigned umin(input int unsigned a, input int unsigned b);
    return a < b ? a : b;
  endfunction

  function automatic res_t make_res(input kind_e k, input logic [7:0] d,
                                    input logic [31:0] w, input reason_e rs,
                                    input logic l);
    res_t r;
    r.kind = k;
    r.data = d;
    r.word = w;
    r.reason = rs;
    r.last = l;
    return r;
  endfunction

  function automatic logic gather_byte(input logic [7:0] b);
    shift_word = {shift_word[23:0], b};
    if (word_cnt == 2'd3) begin
      word_cnt = 2'd0;
      return 1'b1;
    end
    word_cnt = word_cnt + 2'd1;
    return 1'b0;
  endfunction

  function automatic logic length_fits(input logic [31:0] len, input logic [31:0] limit,
                                       input logic [31:0] tail);
    if (len > limit) return 1'b0;
    if ({16'd0, frame_left} < tail) return 1'b0;
    return len <= {16'd0, frame_left} - tail;
  endfunction

  function automatic void skip_frame();
    fail_reason = R_FIELD;
    ph = S_DRAIN;
  endfunction

  function automatic void begin_payload();
    logic [31:0] p;
    p = frame_left >= 16'(TAIL_INFO) ? {16'd0, frame_left} - TAIL_INFO : 32'd0;
    if (p != 0) begin
      field_left = p[15:0];
      ph = S_PAYLOAD;
    end else begin
      ph = S_CHECKSUM;
    end
  endfunction

  function automatic void begin_field(input logic [31:0] len, input parse_e body,
                                      input parse_e empty_next);
    if (len != 0) begin
      field_left = len[15:0];
      ph = body;
    end else if (empty_next == S_PAYLOAD) begin
      begin_payload();
    end else begin
      ph = empty_next;
    end
  endfunction

  // one received byte in, at most one result out
  function automatic logic deframe_step(input logic [7:0] b, output res_t r);
    logic [31:0] total;
    kind_e k;
    r = '0;
    if (ph == S_HUNT) begin
      if (b == cfg.start_marker) begin
        ph = S_TOTAL;
        shift_word = '0;
        word_cnt = '0;
        fail_reason = R_NONE;
      end
      return 1'b0;
    end
    if (ph == S_TOTAL) begin
      if (!gather_byte(b)) return 1'b0;
      total = shift_word;
      if ((total >> LEN_BITS) != 0 || total > cfg.max_frame_bytes || total < FRAME_MIN) begin
        ph = S_HUNT;
        r = make_res(K_REJECT, 8'h00, 32'h0, R_BAD_TOTAL, 1'b1);
        return 1'b1;
      end
      frame_left = 16'(total - 32'd5);
      ph = S_ID_LEN;
      return 1'b0;
    end
    if (frame_left != 0) frame_left = frame_left - 16'd1;
    case (ph)
      S_ID_LEN: begin
        if (gather_byte(b)) begin
          if (!length_fits(shift_word, 32'(cfg.max_id_bytes), TAIL_ID)) skip_frame();
          else begin_field(shift_word, S_ID, S_METHOD_LEN);
        end
      end
      S_ID, S_METHOD, S_INFO, S_PAYLOAD: begin
        case (ph)
          S_ID:     k = K_ID;
          S_METHOD: k = K_METHOD;
          S_INFO:   k = K_INFO;
          default:  k = K_PAYLOAD;
        endcase
        if (field_left != 0) field_left = field_left - 16'd1;
        if (field_left == 0) begin
          case (ph)
            S_ID:     ph = S_METHOD_LEN;
            S_METHOD: ph = S_ERR_CODE;
            S_INFO:   begin_payload();
            default:  ph = S_CHECKSUM;
          endcase
        end
        r = make_res(k, b, 32'h0, R_NONE, 1'b0);
        return 1'b1;
      end
      S_METHOD_LEN: begin
        if (gather_byte(b)) begin
          if (!length_fits(shift_word, 32'(cfg.max_method_bytes), TAIL_METHOD)) skip_frame();
          else begin_field(shift_word, S_METHOD, S_ERR_CODE);
        end
      end
      S_ERR_CODE: begin
        if (gather_byte(b)) begin
          ph = S_INFO_LEN;
          r = make_res(K_ERR_CODE, 8'h00, shift_word, R_NONE, 1'b0);
          return 1'b1;
        end
      end
      S_INFO_LEN: begin
        if (gather_byte(b)) begin
          if (!length_fits(shift_word, 32'(cfg.max_info_bytes), TAIL_INFO)) skip_frame();
          else begin_field(shift_word, S_INFO, S_PAYLOAD);
        end
      end
      S_CHECKSUM: begin
        if (gather_byte(b)) ph = S_END;
      end
      S_END: begin
        ph = S_HUNT;
        if (b == cfg.end_marker) r = make_res(K_ACCEPT, 8'h00, 32'h0, R_NONE, 1'b1);
        else r = make_res(K_REJECT, 8'h00, 32'h0, R_END, 1'b1);
        return 1'b1;
      end
      S_DRAIN: begin
        if (frame_left == 0) begin
          ph = S_HUNT;
          r = make_res(K_REJECT, 8'h00, 32'h0, fail_reason, 1'b1);
          return 1'b1;
        end
      end
      default: ph = S_HUNT;
    endcase
    return 1'b0;
  endfunction

  // result check first, then prediction for the byte taken at this edge
  always @(posedge clk_i) begin : monitor
    res_t want;
    res_t got;
    logic has;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.kind = field_kind_o;
        got.data = data_byte_o;
        got.word = error_code_word_o;
        got.reason = reject_reason_o;
        got.last = frame_last_o;
        if (pending_results.size() == 0) begin
          note($sformatf("unexpected result: kind %0d data %h code %h reason %0d last %0d",
                         got.kind, got.data, got.word, got.reason, got.last));
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind || got.data !== want.data || got.word !== want.word ||
              got.reason !== want.reason || got.last !== want.last) begin
            note($sformatf({"mismatch (exp/act): kind %0d/%0d data %h/%h code %h/%h ",
                            "reason %0d/%0d last %0d/%0d"},
                           want.kind, got.kind, want.data, got.data, want.word, got.word,
                           want.reason, got.reason, want.last, got.last));
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        has = deframe_step(cur_item.b, want);
        if (cur_item.chk == PIN_QUIET) begin
          has = 1'b0;
        end else if (cur_item.chk == PIN_RESULT) begin
          has = 1'b1;
          want = cur_item.res;
        end
        if (has) pending_results.insert(pending_results.size(), want);
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= 12);
  end

  // entered and left at a falling edge
  task automatic send_item(input stim_t it);
    if (!calm && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    cur_item = it;
    rx_byte_i <= it.b;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [4:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    case (addr)
      A_START:      cfg.start_marker = value[7:0];
      A_END:        cfg.end_marker = value[7:0];
      A_MAX_FRAME:  cfg.max_frame_bytes = value[15:0];
      A_MAX_ID:     cfg.max_id_bytes = value[7:0];
      A_MAX_METHOD: cfg.max_method_bytes = value[9:0];
      A_MAX_INFO:   cfg.max_info_bytes = value[9:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input cfg_t c);
    write_reg(A_START, 32'(c.start_marker));
    write_reg(A_END, 32'(c.end_marker));
    write_reg(A_MAX_FRAME, 32'(c.max_frame_bytes));
    write_reg(A_MAX_ID, 32'(c.max_id_bytes));
    write_reg(A_MAX_METHOD, 32'(c.max_method_bytes));
    write_reg(A_MAX_INFO, 32'(c.max_info_bytes));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  function automatic void add_byte(input logic [7:0] v);
    frame_buf.insert(frame_buf.size(), v);
  endfunction

  function automatic void add_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) add_byte(w[8*i +: 8]);
  endfunction

  function automatic void add_random(input int unsigned n);
    repeat (n) add_byte(8'($urandom));
  endfunction

  // one frame, mostly well formed, sometimes damaged in one place, cut short or replaced by noise
  task automatic queue_frame(input bit go_big);
    int unsigned room, cap, lid, lmth, linf, lpay, mode, pick;
    logic [31:0] total, total_word;
    logic [31:0] ln [3];
    logic [31:0] lim [3];
    frame_buf.delete();
    if ($urandom_range(3) == 0) add_random($urandom_range(1, 3));
    cap = go_big ? 80 : (($urandom_range(29) == 0) ? 40 : 6);
    room = cfg.max_frame_bytes >= FRAME_MIN ? 32'(cfg.max_frame_bytes) - FRAME_MIN : 0;
    lid = umin($urandom_range(0, umin(cap, 32'(cfg.max_id_bytes))), room);
    room -= lid;
    lmth = umin($urandom_range(0, umin(cap, 32'(cfg.max_method_bytes))), room);
    room -= lmth;
    linf = umin($urandom_range(0, umin(cap, 32'(cfg.max_info_bytes))), room);
    room -= linf;
    lpay = umin($urandom_range(0, cap), room);
    total = FRAME_MIN + lid + lmth + linf + lpay;
    ln = '{lid, lmth, linf};
    lim = '{32'(cfg.max_id_bytes), 32'(cfg.max_method_bytes), 32'(cfg.max_info_bytes)};
    mode = $urandom_range(99);
    pick = $urandom_range(2);
    if (mode >= 70 && mode < 78) ln[pick] = lim[pick] + 1 + $urandom_range(3);
    else if (mode >= 78 && mode < 85) ln[pick] = $urandom_range(1) ? total : $urandom();
    total_word = total;
    if (mode >= 85 && mode < 92) begin
      case ($urandom_range(2))
        0:       total_word = $urandom_range(0, FRAME_MIN - 1);
        1:       total_word = 32'(cfg.max_frame_bytes) + 1 + $urandom_range(3);
        default: total_word = $urandom() | 32'h0001_0000;
      endcase
    end
    add_byte(cfg.start_marker);
    add_word(total_word);
    if (mode >= 85 && mode < 92 && $urandom_range(1) == 0) return;
    add_word(ln[0]);
    add_random(lid);
    add_word(ln[1]);
    add_random(lmth);
    add_word($urandom());
    add_word(ln[2]);
    add_random(linf + lpay + 4);
    if (mode >= 60 && mode < 70) add_byte(cfg.end_marker ^ (8'd1 << $urandom_range(7)));
    else add_byte(cfg.end_marker);
    if (mode >= 92 && mode < 97) begin
      repeat ($urandom_range(1, frame_buf.size() - 1)) void'(frame_buf.pop_back());
    end else if (mode >= 97) begin
      frame_buf.delete();
      add_random($urandom_range(1, 8));
    end
  endtask

  task automatic run_frames(input int unsigned n, input bit big_first);
    int unsigned sent;
    bit first;
    sent = 0;
    first = big_first;
    while (sent < n) begin
      queue_frame(first);
      first = 1'b0;
      foreach (frame_buf[i]) send_item('{b: frame_buf[i], chk: BY_MODEL, res: NO_RES});
      sent += frame_buf.size();
    end
  endtask

  initial begin : stimulus
    cfg_t rc;
    int unsigned spin;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED[i]) send_item(DIRECTED[i]);
    settle();
    calm = 1'b1;
    run_frames(90, 1'b0);
    calm = 1'b0;
    run_frames(70, 1'b0);

    settle();
    apply_config(CFG_LOW);
    run_frames(110, 1'b0);

    settle();
    apply_config(CFG_HIGH);
    run_frames(100, 1'b1);

    settle();
    rc.start_marker = 8'($urandom);
    rc.end_marker = 8'($urandom);
    rc.max_frame_bytes = 16'($urandom_range(FRAME_MIN, 3000));
    rc.max_id_bytes = 8'($urandom);
    rc.max_method_bytes = 10'($urandom);
    rc.max_info_bytes = 10'($urandom);
    apply_config(rc);
    run_frames(90, 1'b0);

    in_valid_i <= 1'b0;
    spin = 0;
    while (pending_results.size() != 0 && spin < 20000) begin
      @(posedge clk_i);
      spin++;
    end
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      note($sformatf("%0d expected results never arrived", pending_results.size()));
    end
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
